// ===== rtl/ftm_pkg.sv =====
// Shared package for the fixed-step move-to-target core.
// Holds widths, operation and register codes, controller states and the
// command/status structs between controller and datapath. No dependencies.
package ftm_pkg;

    localparam int CW        = 24;
    localparam int FB        = 8;
    localparam int SPD_W     = 16;
    localparam int ROOT_W    = CW + 1;
    localparam int RAD_W     = 2 * ROOT_W;
    localparam int SQ_W      = 2 * CW;
    localparam int PROD_W    = CW + SPD_W;
    localparam int CNT_W     = $clog2(ROOT_W);
    localparam int CFG_IDX_W = 3;

    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_W - 1);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(CW - 1);

    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_X = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_Y = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_X = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_Y = CFG_IDX_W'(4);

    typedef enum logic [1:0] {
        OP_TICK,
        OP_START,
        OP_HOME,
        OP_PLACE
    } t_op;

    typedef enum logic [1:0] {
        FIN_OP,
        FIN_SNAP,
        FIN_STEP
    } t_fin;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_SQUARE,
        ST_SUM,
        ST_ROOT,
        ST_CHECK,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic load;
        logic cap_diff;
        logic square;
        logic sum;
        logic root_step;
        logic mul;
        logic div_init;
        logic div_step;
        logic commit;
        t_fin fin;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic moving;
        logic near;
        logic snap;
    } t_sts;

endpackage

// ===== rtl/ftm_ctrl.sv =====
// Controller of the fixed-step move-to-target core.
// Sequences accept, distance root, scaling and division; owns result valid.
// Depends on ftm_pkg.
module ftm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    input  ftm_pkg::t_sts i_sts,
    output ftm_pkg::t_cmd o_cmd
);

    ftm_pkg::t_state                r_state, n_state;
    logic [ftm_pkg::CNT_W-1:0]      r_cnt, n_cnt;
    ftm_pkg::t_fin                  r_fin, n_fin;
    logic                           r_out_valid, n_out_valid;
    logic                           out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == ftm_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ftm_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_fin       <= ftm_pkg::FIN_OP;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_fin       <= n_fin;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_fin     = r_fin;
        o_cmd     = '0;
        o_cmd.fin = r_fin;
        unique case (r_state)
            ftm_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ftm_pkg::ST_DECIDE;
                end
            end
            ftm_pkg::ST_DECIDE: begin
                o_cmd.cap_diff = 1'b1;
                if (!i_sts.is_tick || !i_sts.moving) begin
                    n_fin   = ftm_pkg::FIN_OP;
                    n_state = ftm_pkg::ST_FINISH;
                end else if (i_sts.near) begin
                    n_fin   = ftm_pkg::FIN_SNAP;
                    n_state = ftm_pkg::ST_FINISH;
                end else begin
                    n_state = ftm_pkg::ST_SQUARE;
                end
            end
            ftm_pkg::ST_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = ftm_pkg::ST_SUM;
            end
            ftm_pkg::ST_SUM: begin
                o_cmd.sum = 1'b1;
                n_cnt     = '0;
                n_state   = ftm_pkg::ST_ROOT;
            end
            ftm_pkg::ST_ROOT: begin
                o_cmd.root_step = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == ftm_pkg::ROOT_LAST) begin
                    n_state = ftm_pkg::ST_CHECK;
                end
            end
            ftm_pkg::ST_CHECK: begin
                if (i_sts.snap) begin
                    n_fin   = ftm_pkg::FIN_SNAP;
                    n_state = ftm_pkg::ST_FINISH;
                end else begin
                    n_state = ftm_pkg::ST_MUL;
                end
            end
            ftm_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ftm_pkg::ST_DIV_INIT;
            end
            ftm_pkg::ST_DIV_INIT: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = '0;
                n_state        = ftm_pkg::ST_DIV;
            end
            ftm_pkg::ST_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == ftm_pkg::DIV_LAST) begin
                    n_fin   = ftm_pkg::FIN_STEP;
                    n_state = ftm_pkg::ST_FINISH;
                end
            end
            ftm_pkg::ST_FINISH: begin
                if (out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ftm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ftm_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.commit) begin
            n_out_valid = 1'b1;
        end
    end

endmodule

// ===== rtl/ftm_dp.sv =====
// Datapath of the fixed-step move-to-target core.
// Holds configuration, position, target and moving flag, the bit-serial root
// and the two bit-serial dividers, and the result register. Depends on ftm_pkg.
module ftm_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ftm_pkg::t_cmd                       i_cmd,
    output ftm_pkg::t_sts                       o_sts,
    input  logic                                i_cfg_we,
    input  logic [ftm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ftm_pkg::CW-1:0]              i_cfg_data,
    input  logic [1:0]                          i_operation,
    input  logic signed [ftm_pkg::CW-1:0]       i_place_x,
    input  logic signed [ftm_pkg::CW-1:0]       i_place_y,
    output logic signed [ftm_pkg::CW-1:0]       o_pos_x,
    output logic signed [ftm_pkg::CW-1:0]       o_pos_y,
    output logic                                o_is_moving,
    output logic                                o_arrived
);

    logic [ftm_pkg::CW-1:0]     r_goal_x, r_goal_y, r_home_x, r_home_y;
    logic [ftm_pkg::SPD_W-1:0]  r_speed;
    logic [ftm_pkg::CW-1:0]     r_cur_x, r_cur_y, r_tgt_x, r_tgt_y;
    logic                       r_moving;
    ftm_pkg::t_op               r_op;
    logic [ftm_pkg::CW-1:0]     r_place_x, r_place_y;
    logic [ftm_pkg::CW-1:0]     r_ax, r_ay;
    logic                       r_sx, r_sy;
    logic [ftm_pkg::SQ_W-1:0]   r_sqx, r_sqy;
    logic [ftm_pkg::RAD_W-1:0]  r_rad;
    logic [ftm_pkg::ROOT_W-1:0] r_root;
    logic [ftm_pkg::ROOT_W:0]   r_srem;
    logic [ftm_pkg::PROD_W-1:0] r_px, r_py;
    logic [ftm_pkg::ROOT_W-1:0] r_rx, r_ry;
    logic [ftm_pkg::CW-1:0]     r_qx, r_qy;
    logic [ftm_pkg::CW-1:0]     r_out_x, r_out_y;
    logic                       r_out_moving, r_out_arrived;

    logic [ftm_pkg::CW:0]       dx, dy, ndx, ndy;
    logic [ftm_pkg::CW-1:0]     ax, ay;
    logic [ftm_pkg::ROOT_W+2:0] s_t, s_trial, s_diff;
    logic                       s_ge;
    logic [ftm_pkg::ROOT_W:0]   dx_t, dy_t, d_div, dx_diff, dy_diff;
    logic                       dx_ge, dy_ge;
    logic [ftm_pkg::ROOT_W-1:0] spd_ext;
    logic [ftm_pkg::CW-1:0]     step_x, step_y;
    logic [ftm_pkg::CW-1:0]     n_cur_x, n_cur_y, n_tgt_x, n_tgt_y;
    logic                       n_moving, n_arrived;

    // distance to target
    assign dx  = {r_tgt_x[ftm_pkg::CW-1], r_tgt_x} - {r_cur_x[ftm_pkg::CW-1], r_cur_x};
    assign dy  = {r_tgt_y[ftm_pkg::CW-1], r_tgt_y} - {r_cur_y[ftm_pkg::CW-1], r_cur_y};
    assign ndx = -dx;
    assign ndy = -dy;
    assign ax  = dx[ftm_pkg::CW] ? ndx[ftm_pkg::CW-1:0] : dx[ftm_pkg::CW-1:0];
    assign ay  = dy[ftm_pkg::CW] ? ndy[ftm_pkg::CW-1:0] : dy[ftm_pkg::CW-1:0];

    // root digit step
    assign s_t     = {r_srem, r_rad[ftm_pkg::RAD_W-1 -: 2]};
    assign s_trial = {1'b0, r_root, 2'b01};
    assign s_ge    = (s_t >= s_trial);
    assign s_diff  = s_t - s_trial;

    // divider steps
    assign d_div   = {1'b0, r_root};
    assign dx_t    = {r_rx, r_qx[ftm_pkg::CW-1]};
    assign dy_t    = {r_ry, r_qy[ftm_pkg::CW-1]};
    assign dx_ge   = (dx_t >= d_div);
    assign dy_ge   = (dy_t >= d_div);
    assign dx_diff = dx_t - d_div;
    assign dy_diff = dy_t - d_div;

    assign spd_ext = ftm_pkg::ROOT_W'(r_speed);

    assign o_sts.is_tick = (r_op == ftm_pkg::OP_TICK);
    assign o_sts.moving  = r_moving;
    assign o_sts.near    = (ax[ftm_pkg::CW-1:ftm_pkg::FB] == '0) &&
                           (ay[ftm_pkg::CW-1:ftm_pkg::FB] == '0);
    assign o_sts.snap    = (spd_ext > r_root) || ((spd_ext == r_root) && (r_srem == '0));

    assign step_x = r_sx ? -r_qx : r_qx;
    assign step_y = r_sy ? -r_qy : r_qy;

    always_comb begin
        n_cur_x   = r_cur_x;
        n_cur_y   = r_cur_y;
        n_tgt_x   = r_tgt_x;
        n_tgt_y   = r_tgt_y;
        n_moving  = r_moving;
        n_arrived = 1'b0;
        unique case (i_cmd.fin)
            ftm_pkg::FIN_OP: begin
                unique case (r_op)
                    ftm_pkg::OP_START: begin
                        n_tgt_x  = r_goal_x;
                        n_tgt_y  = r_goal_y;
                        n_moving = 1'b1;
                    end
                    ftm_pkg::OP_HOME: begin
                        n_tgt_x  = r_home_x;
                        n_tgt_y  = r_home_y;
                        n_moving = 1'b1;
                    end
                    ftm_pkg::OP_PLACE: begin
                        n_cur_x = r_place_x;
                        n_cur_y = r_place_y;
                    end
                    default: begin
                    end
                endcase
            end
            ftm_pkg::FIN_SNAP: begin
                n_cur_x   = r_tgt_x;
                n_cur_y   = r_tgt_y;
                n_moving  = 1'b0;
                n_arrived = 1'b1;
            end
            ftm_pkg::FIN_STEP: begin
                n_cur_x = r_cur_x + step_x;
                n_cur_y = r_cur_y + step_y;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal_x <= '0;
            r_goal_y <= '0;
            r_speed  <= '0;
            r_home_x <= '0;
            r_home_y <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ftm_pkg::CFG_GOAL_X: r_goal_x <= i_cfg_data;
                ftm_pkg::CFG_GOAL_Y: r_goal_y <= i_cfg_data;
                ftm_pkg::CFG_SPEED:  r_speed  <= i_cfg_data[ftm_pkg::SPD_W-1:0];
                ftm_pkg::CFG_HOME_X: r_home_x <= i_cfg_data;
                ftm_pkg::CFG_HOME_Y: r_home_y <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x  <= '0;
            r_cur_y  <= '0;
            r_tgt_x  <= '0;
            r_tgt_y  <= '0;
            r_moving <= 1'b0;
        end else if (i_cmd.commit) begin
            r_cur_x  <= n_cur_x;
            r_cur_y  <= n_cur_y;
            r_tgt_x  <= n_tgt_x;
            r_tgt_y  <= n_tgt_y;
            r_moving <= n_moving;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= ftm_pkg::t_op'(i_operation);
            r_place_x <= i_place_x;
            r_place_y <= i_place_y;
        end
        if (i_cmd.cap_diff) begin
            r_ax <= ax;
            r_ay <= ay;
            r_sx <= dx[ftm_pkg::CW];
            r_sy <= dy[ftm_pkg::CW];
        end
        if (i_cmd.square) begin
            r_sqx <= r_ax * r_ax;
            r_sqy <= r_ay * r_ay;
        end
        if (i_cmd.sum) begin
            r_rad  <= ftm_pkg::RAD_W'(r_sqx) + ftm_pkg::RAD_W'(r_sqy);
            r_root <= '0;
            r_srem <= '0;
        end
        if (i_cmd.root_step) begin
            r_rad  <= {r_rad[ftm_pkg::RAD_W-3:0], 2'b00};
            r_root <= {r_root[ftm_pkg::ROOT_W-2:0], s_ge};
            r_srem <= s_ge ? s_diff[ftm_pkg::ROOT_W:0] : s_t[ftm_pkg::ROOT_W:0];
        end
        if (i_cmd.mul) begin
            r_px <= r_ax * r_speed;
            r_py <= r_ay * r_speed;
        end
        if (i_cmd.div_init) begin
            r_rx <= ftm_pkg::ROOT_W'(r_px[ftm_pkg::PROD_W-1:ftm_pkg::CW]);
            r_ry <= ftm_pkg::ROOT_W'(r_py[ftm_pkg::PROD_W-1:ftm_pkg::CW]);
            r_qx <= r_px[ftm_pkg::CW-1:0];
            r_qy <= r_py[ftm_pkg::CW-1:0];
        end
        if (i_cmd.div_step) begin
            r_rx <= dx_ge ? dx_diff[ftm_pkg::ROOT_W-1:0] : dx_t[ftm_pkg::ROOT_W-1:0];
            r_ry <= dy_ge ? dy_diff[ftm_pkg::ROOT_W-1:0] : dy_t[ftm_pkg::ROOT_W-1:0];
            r_qx <= {r_qx[ftm_pkg::CW-2:0], dx_ge};
            r_qy <= {r_qy[ftm_pkg::CW-2:0], dy_ge};
        end
        if (i_cmd.commit) begin
            r_out_x       <= n_cur_x;
            r_out_y       <= n_cur_y;
            r_out_moving  <= n_moving;
            r_out_arrived <= n_arrived;
        end
    end

    assign o_pos_x     = r_out_x;
    assign o_pos_y     = r_out_y;
    assign o_is_moving = r_out_moving;
    assign o_arrived   = r_out_arrived;

endmodule

// ===== rtl/fixed_step_move_to_target_core.sv =====
// Top level of the fixed-step move-to-target core.
// Joins the controller ftm_ctrl and the datapath ftm_dp. Depends on ftm_pkg.
//
// Input channel: i_in_valid / o_in_ready carry one item (operation, place_x,
// place_y). Output channel: o_out_valid / i_out_ready carry one result
// (pos_x, pos_y, is_moving, arrived) for every item, in order.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index
// (0 goal_x, 1 goal_y, 2 step_speed, 3 home_x, 4 home_y); others ignored.
// Start, return, place, idle ticks and ticks that snap within one unit
// finish without arithmetic; a tick that snaps after the distance root
// runs the 25-step root; a tick that advances runs the root and then
// two 24-step dividers.
// One item is in work at a time; o_in_ready rises the cycle after the
// result is loaded into the output register, so the next item may be
// taken while that result still waits.
// When the receiver stalls, the result holds in the output register and a
// finished item waits in its last step until the register frees.
// Reset (synchronous, active low) clears configuration, position, target,
// moving flag and the output valid.
module fixed_step_move_to_target_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [1:0]                          i_operation,
    input  logic signed [ftm_pkg::CW-1:0]       i_place_x,
    input  logic signed [ftm_pkg::CW-1:0]       i_place_y,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic signed [ftm_pkg::CW-1:0]       o_pos_x,
    output logic signed [ftm_pkg::CW-1:0]       o_pos_y,
    output logic                                o_is_moving,
    output logic                                o_arrived,
    input  logic                                i_cfg_we,
    input  logic [ftm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ftm_pkg::CW-1:0]              i_cfg_data
);

    ftm_pkg::t_cmd s_cmd;
    ftm_pkg::t_sts s_sts;

    ftm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .i_sts       (s_sts),
        .o_cmd       (s_cmd)
    );

    ftm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (s_cmd),
        .o_sts       (s_sts),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_operation (i_operation),
        .i_place_x   (i_place_x),
        .i_place_y   (i_place_y),
        .o_pos_x     (o_pos_x),
        .o_pos_y     (o_pos_y),
        .o_is_moving (o_is_moving),
        .o_arrived   (o_arrived)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in work");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.commit |-> (!o_out_valid || i_out_ready))
        else $error("result register overwritten while stalled");

    a_commit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_cmd.commit |=> o_out_valid)
        else $error("committed result not presented");

    a_arrived_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_arrived) |-> !o_is_moving)
        else $error("arrival reported while still moving");

endmodule
